@@ rtl/assert_macros.svh @@
// Assertion macros shared by the lock controller RTL.
// Uses the including module's clk and rst; empty when SYNTHESIS is set.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define KCLC_ASSERT(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed");
`define KCLC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define KCLC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define KCLC_ASSERT(lbl, expr)
`define KCLC_ASSERT_IMP(lbl, ante, cons)
`define KCLC_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

@@ rtl/kclc_pkg.sv @@
// Types, codes and constants of the keypad code lock controller.
// No dependencies.
`timescale 1ns / 1ps
package kclc_pkg;

  localparam int MAX_DIGITS_DEF = 8;
  localparam int RESET_CODE_LEN = 4;
  localparam logic [15:0] TIMEOUT_RESET = 16'd2000;
  localparam logic [15:0] TICKS_MAX = 16'hFFFF;

  typedef logic [3:0] digit_t;

  localparam digit_t KEY_DIGIT_MAX = 4'd9;
  localparam digit_t KEY_STAR = 4'd10;
  localparam digit_t KEY_HASH = 4'd11;
  localparam digit_t KEY_OPT_LOCK = 4'd0;
  localparam digit_t KEY_OPT_UNLOCK = 4'd1;
  localparam digit_t KEY_OPT_CHANGE = 4'd2;
  localparam digit_t KEY_OPT_STATUS = 4'd3;

  typedef enum logic [9:0] {
    ST_IDLE   = 10'b0000000001,
    ST_MENU   = 10'b0000000010,
    ST_LOCK   = 10'b0000000100,
    ST_UWAIT  = 10'b0000001000,
    ST_UENTRY = 10'b0000010000,
    ST_CWAIT  = 10'b0000100000,
    ST_OLD    = 10'b0001000000,
    ST_NEW    = 10'b0010000000,
    ST_STATUS = 10'b0100000000,
    ST_RESULT = 10'b1000000000
  } state_t;

  typedef enum logic [3:0] {
    CODE_IDLE   = 4'd0,
    CODE_MENU   = 4'd1,
    CODE_LOCK   = 4'd2,
    CODE_UWAIT  = 4'd3,
    CODE_UENTRY = 4'd4,
    CODE_CWAIT  = 4'd5,
    CODE_OLD    = 4'd6,
    CODE_NEW    = 4'd7,
    CODE_STATUS = 4'd8,
    CODE_RESULT = 4'd9
  } state_code_t;

  typedef enum logic [3:0] {
    MSG_NONE          = 4'd0,
    MSG_INVALID       = 4'd1,
    MSG_LOCKED        = 4'd2,
    MSG_NEED_UNLOCK   = 4'd3,
    MSG_GRANTED       = 4'd4,
    MSG_WRONG_CODE    = 4'd5,
    MSG_NEED_CHANGE   = 4'd6,
    MSG_NEED_NEW      = 4'd7,
    MSG_CHANGED       = 4'd8,
    MSG_EMPTY_NEW     = 4'd9,
    MSG_WRONG_OLD     = 4'd10,
    MSG_STAT_LOCKED   = 4'd11,
    MSG_STAT_UNLOCKED = 4'd12
  } msg_t;

  function automatic state_code_t state_code(state_t s);
    state_code_t c;
    case (s)
      ST_MENU:   c = CODE_MENU;
      ST_LOCK:   c = CODE_LOCK;
      ST_UWAIT:  c = CODE_UWAIT;
      ST_UENTRY: c = CODE_UENTRY;
      ST_CWAIT:  c = CODE_CWAIT;
      ST_OLD:    c = CODE_OLD;
      ST_NEW:    c = CODE_NEW;
      ST_STATUS: c = CODE_STATUS;
      ST_RESULT: c = CODE_RESULT;
      default:   c = CODE_IDLE;
    endcase
    return c;
  endfunction

  // factory code 1,2,3,4 then zeros
  function automatic digit_t reset_digit(int i);
    digit_t d;
    if (i < RESET_CODE_LEN) begin
      d = 4'(i + 1);
    end else begin
      d = 4'd0;
    end
    return d;
  endfunction

endpackage

@@ rtl/kclc_key_if.sv @@
// Key/tick input channel of the lock controller.
// Depends on kclc_pkg.
`timescale 1ns / 1ps
interface kclc_key_if
  import kclc_pkg::*;
();
  logic   valid;
  logic   ready;
  logic   action;
  digit_t key_code;

  modport source (output valid, output action, output key_code, input ready);
  modport sink (input valid, input action, input key_code, output ready);
endinterface

@@ rtl/kclc_report_if.sv @@
// Result channel of the lock controller.
// Depends on kclc_pkg.
`timescale 1ns / 1ps
interface kclc_report_if
  import kclc_pkg::*;
();
  logic       valid;
  logic       ready;
  logic [3:0] machine_state;
  logic       locked;
  logic [3:0] entered_count;
  logic [3:0] message;

  modport source (output valid, output machine_state, output locked,
                  output entered_count, output message, input ready);
  modport sink (input valid, input machine_state, input locked,
                input entered_count, input message, output ready);
endinterface

@@ rtl/keypad_code_lock_controller.sv @@
// The result of an accepted key/tick transaction is registered at the accept edge.
// Throughput: one transaction per cycle while not stalled; the menu state, code
// buffers and the result register all update in a single pass at the accept edge.
// The output register frees input ready whenever it is empty or being taken.
// Reset (rst, synchronous): idle, locked, code 1234, timeout 2000, no result pending.
// Depends on kclc_pkg, kclc_key_if, kclc_report_if, assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module keypad_code_lock_controller
  import kclc_pkg::*;
#(
  parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  kclc_key_if.sink      keys,
  kclc_report_if.source report,
  input  logic          cfg_wr_en,
  input  logic [15:0]   cfg_wr_data
);

  localparam int LEN_W = $clog2(MAX_DIGITS + 1);
  localparam int IDX_W = $clog2(MAX_DIGITS);
  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_DIGITS);

  state_t           state, state_next;
  logic             door_locked, locked_next;
  logic [LEN_W-1:0] entry_length, elen_next;
  logic [LEN_W-1:0] old_length, olen_next;
  logic [LEN_W-1:0] stored_length, slen_next;
  logic [15:0]      result_ticks, ticks_next, ticks_inc;
  logic [15:0]      timeout;
  msg_t             msg_next;
  logic             add_dig, copy_old, copy_stored;

  digit_t entry_digits [MAX_DIGITS];
  digit_t old_digits [MAX_DIGITS];
  digit_t stored_code [MAX_DIGITS];

  logic [MAX_DIGITS-1:0] unl_hit, old_hit;
  logic                  unlock_ok, old_ok, is_digit, accept;
  logic [31:0]           count_ext;

  logic        out_valid;
  state_code_t out_state;
  logic        out_locked;
  logic [3:0]  out_count;
  msg_t        out_msg;

  assign keys.ready = !out_valid || report.ready;
  assign accept = keys.valid && keys.ready;
  assign is_digit = keys.key_code <= KEY_DIGIT_MAX;

  always_comb begin
    for (int i = 0; i < MAX_DIGITS; i++) begin
      unl_hit[i] = (LEN_W'(i) >= entry_length) || (entry_digits[i] == stored_code[i]);
      old_hit[i] = (LEN_W'(i) >= old_length) || (old_digits[i] == stored_code[i]);
    end
    unlock_ok = (entry_length == stored_length) && (&unl_hit);
    old_ok = (old_length == stored_length) && (&old_hit);
  end

  assign ticks_inc = (result_ticks != TICKS_MAX) ? result_ticks + 16'd1 : result_ticks;

  always_comb begin
    state_next = state;
    locked_next = door_locked;
    elen_next = entry_length;
    olen_next = old_length;
    slen_next = stored_length;
    ticks_next = result_ticks;
    msg_next = MSG_NONE;
    add_dig = 1'b0;
    copy_old = 1'b0;
    copy_stored = 1'b0;
    if (keys.action) begin
      if (state == ST_RESULT) begin
        ticks_next = ticks_inc;
        if (ticks_inc >= timeout) begin
          state_next = ST_IDLE;
        end
      end
    end else begin
      case (state)
        ST_MENU: begin
          if (keys.key_code == KEY_OPT_LOCK) begin
            state_next = ST_LOCK;
          end else if (keys.key_code == KEY_OPT_UNLOCK) begin
            state_next = ST_UWAIT;
          end else if (keys.key_code == KEY_OPT_CHANGE) begin
            state_next = ST_CWAIT;
          end else if (keys.key_code == KEY_OPT_STATUS) begin
            state_next = ST_STATUS;
          end else if (keys.key_code != KEY_STAR) begin
            state_next = ST_RESULT;
            ticks_next = '0;
            msg_next = MSG_INVALID;
          end
        end
        ST_LOCK: begin
          if (keys.key_code == KEY_HASH) begin
            locked_next = 1'b1;
            state_next = ST_RESULT;
            ticks_next = '0;
            msg_next = MSG_LOCKED;
          end else if (keys.key_code == KEY_STAR) begin
            state_next = ST_MENU;
          end
        end
        ST_UWAIT, ST_CWAIT: begin
          if (keys.key_code == KEY_STAR) begin
            elen_next = '0;
            state_next = (state == ST_UWAIT) ? ST_UENTRY : ST_OLD;
          end else if (keys.key_code == KEY_HASH) begin
            state_next = ST_RESULT;
            ticks_next = '0;
            msg_next = (state == ST_UWAIT) ? MSG_NEED_UNLOCK : MSG_NEED_CHANGE;
          end
        end
        ST_UENTRY: begin
          if (is_digit) begin
            if (entry_length < LEN_MAX) begin
              add_dig = 1'b1;
              elen_next = entry_length + 1'b1;
            end
          end else if (keys.key_code == KEY_HASH) begin
            state_next = ST_RESULT;
            ticks_next = '0;
            elen_next = '0;
            if (unlock_ok) begin
              locked_next = 1'b0;
              msg_next = MSG_GRANTED;
            end else begin
              msg_next = MSG_WRONG_CODE;
            end
          end else if (keys.key_code == KEY_STAR) begin
            elen_next = '0;
          end
        end
        ST_OLD: begin
          if (is_digit) begin
            if (entry_length < LEN_MAX) begin
              add_dig = 1'b1;
              elen_next = entry_length + 1'b1;
            end
          end else if (keys.key_code == KEY_STAR) begin
            copy_old = 1'b1;
            olen_next = entry_length;
            elen_next = '0;
            state_next = ST_NEW;
          end else if (keys.key_code == KEY_HASH) begin
            state_next = ST_RESULT;
            ticks_next = '0;
            msg_next = MSG_NEED_NEW;
          end
        end
        ST_NEW: begin
          if (is_digit) begin
            if (entry_length < LEN_MAX) begin
              add_dig = 1'b1;
              elen_next = entry_length + 1'b1;
            end
          end else if (keys.key_code == KEY_HASH) begin
            state_next = ST_RESULT;
            ticks_next = '0;
            elen_next = '0;
            olen_next = '0;
            if (!old_ok) begin
              msg_next = MSG_WRONG_OLD;
            end else if (entry_length != '0) begin
              copy_stored = 1'b1;
              slen_next = entry_length;
              msg_next = MSG_CHANGED;
            end else begin
              msg_next = MSG_EMPTY_NEW;
            end
          end else if (keys.key_code == KEY_STAR) begin
            elen_next = '0;
          end
        end
        ST_STATUS: begin
          if (keys.key_code == KEY_HASH) begin
            state_next = ST_RESULT;
            ticks_next = '0;
            msg_next = door_locked ? MSG_STAT_LOCKED : MSG_STAT_UNLOCKED;
          end else if (keys.key_code == KEY_STAR) begin
            state_next = ST_MENU;
          end
        end
        default: begin
          state_next = (keys.key_code == KEY_STAR) ? ST_MENU : ST_IDLE;
        end
      endcase
    end
  end

  assign count_ext = 32'(elen_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      door_locked <= 1'b1;
      entry_length <= '0;
      old_length <= '0;
      stored_length <= LEN_W'(RESET_CODE_LEN);
      result_ticks <= '0;
      timeout <= TIMEOUT_RESET;
      out_valid <= 1'b0;
      for (int i = 0; i < MAX_DIGITS; i++) begin
        stored_code[i] <= reset_digit(i);
      end
    end else begin
      if (cfg_wr_en) begin
        timeout <= cfg_wr_data;
      end
      if (accept) begin
        state <= state_next;
        door_locked <= locked_next;
        entry_length <= elen_next;
        old_length <= olen_next;
        stored_length <= slen_next;
        result_ticks <= ticks_next;
        out_valid <= 1'b1;
        if (copy_stored) begin
          for (int i = 0; i < MAX_DIGITS; i++) begin
            stored_code[i] <= entry_digits[i];
          end
        end
      end else if (report.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_state <= state_code(state_next);
      out_locked <= locked_next;
      out_count <= count_ext[3:0];
      out_msg <= msg_next;
      if (add_dig) begin
        entry_digits[entry_length[IDX_W-1:0]] <= keys.key_code;
      end
      if (copy_old) begin
        for (int i = 0; i < MAX_DIGITS; i++) begin
          old_digits[i] <= entry_digits[i];
        end
      end
    end
  end

  assign report.valid = out_valid;
  assign report.machine_state = out_state;
  assign report.locked = out_locked;
  assign report.entered_count = out_count;
  assign report.message = out_msg;

  `KCLC_ASSERT(a_len_bound, (entry_length <= LEN_MAX) && (old_length <= LEN_MAX))
  `KCLC_ASSERT(a_code_not_empty, stored_length != '0)
  `KCLC_ASSERT_IMP(a_msg_only_in_result, out_valid && (out_msg != MSG_NONE),
                   out_state == CODE_RESULT)
  `KCLC_ASSERT_NEXT(a_tick_outside_result, accept && keys.action && (state != ST_RESULT),
                    $stable(state))
  `KCLC_ASSERT_IMP(a_unlock_by_code, $fell(door_locked), out_msg == MSG_GRANTED)

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for keypad_code_lock_controller: directed menu walks, then
// random lock/unlock/change/status sessions under several timeout settings.
// Depends on kclc_pkg, kclc_key_if, kclc_report_if and the controller RTL.
module tb_top;
  import kclc_pkg::*;

  localparam int     ND             = MAX_DIGITS_DEF;
  localparam int     WATCHDOG_LIMIT = 3000;
  localparam int     HOLD_CYCLES    = 300;
  localparam int     LONG_TICKS     = 100;
  localparam logic   ACT_KEY        = 1'b0;
  localparam logic   ACT_TICK       = 1'b1;
  localparam digit_t KEY_OTHER      = 4'd12;

  typedef logic [ND-1:0][3:0] code_buf_t;

  typedef struct packed {
    state_code_t st;
    logic        lk;
    logic [3:0]  cnt;
    msg_t        msg;
  } lock_report_t;

  logic        clk;
  logic        rst;
  logic        cfg_wr_en;
  logic [15:0] cfg_wr_data;

  kclc_key_if    key_ch ();
  kclc_report_if res_ch ();

  keypad_code_lock_controller i_dut (
    .clk         (clk),
    .rst         (rst),
    .keys        (key_ch),
    .report      (res_ch),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  // lock model state
  state_code_t mdl_state     = CODE_IDLE;
  logic        mdl_locked    = 1'b1;
  code_buf_t   mdl_code      = 32'h0000_4321;
  logic [3:0]  mdl_code_len  = 4'd4;
  code_buf_t   mdl_entry     = '0;
  logic [3:0]  mdl_entry_len = 4'd0;
  code_buf_t   mdl_old       = '0;
  logic [3:0]  mdl_old_len   = 4'd0;
  logic [15:0] mdl_ticks     = 16'd0;
  logic [15:0] mdl_timeout   = TIMEOUT_RESET;

  lock_report_t expected_reports[$];
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_starts   = 0;
  int hold_seen     = 0;
  int hold_left     = 0;
  int items_sent    = 0;
  int checked       = 0;
  int errors        = 0;
  int stall_cycles  = 0;
  int msg_count[16];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic bit same_code(code_buf_t a, logic [3:0] alen, code_buf_t b,
                                   logic [3:0] blen);
    bit eq;
    eq = (alen == blen) && (alen <= ND);
    for (int i = 0; i < ND; i++) begin
      if (eq && i < alen && a[i] != b[i]) eq = 1'b0;
    end
    return eq;
  endfunction

  function automatic msg_t enter_result(msg_t m);
    mdl_state = CODE_RESULT;
    mdl_ticks = '0;
    return m;
  endfunction

  function automatic void push_digit(digit_t d);
    if (mdl_entry_len < ND) begin
      mdl_entry[mdl_entry_len[2:0]] = d;
      mdl_entry_len = mdl_entry_len + 1'b1;
    end
  endfunction

  function automatic lock_report_t predict_lock_step(logic act, digit_t key);
    msg_t         m;
    lock_report_t r;
    m = MSG_NONE;
    if (act == ACT_TICK) begin
      if (mdl_state == CODE_RESULT) begin
        if (mdl_ticks != TICKS_MAX) mdl_ticks = mdl_ticks + 1'b1;
        if (mdl_ticks >= mdl_timeout) mdl_state = CODE_IDLE;
      end
    end else begin
      case (mdl_state)
        CODE_MENU: begin
          if (key == KEY_OPT_LOCK) mdl_state = CODE_LOCK;
          else if (key == KEY_OPT_UNLOCK) mdl_state = CODE_UWAIT;
          else if (key == KEY_OPT_CHANGE) mdl_state = CODE_CWAIT;
          else if (key == KEY_OPT_STATUS) mdl_state = CODE_STATUS;
          else if (key != KEY_STAR) m = enter_result(MSG_INVALID);
        end
        CODE_LOCK: begin
          if (key == KEY_HASH) begin
            mdl_locked = 1'b1;
            m = enter_result(MSG_LOCKED);
          end else if (key == KEY_STAR) begin
            mdl_state = CODE_MENU;
          end
        end
        CODE_UWAIT: begin
          if (key == KEY_STAR) begin
            mdl_entry_len = '0;
            mdl_state = CODE_UENTRY;
          end else if (key == KEY_HASH) begin
            m = enter_result(MSG_NEED_UNLOCK);
          end
        end
        CODE_UENTRY: begin
          if (key <= KEY_DIGIT_MAX) begin
            push_digit(key);
          end else if (key == KEY_HASH) begin
            if (same_code(mdl_entry, mdl_entry_len, mdl_code, mdl_code_len)) begin
              mdl_locked = 1'b0;
              m = enter_result(MSG_GRANTED);
            end else begin
              m = enter_result(MSG_WRONG_CODE);
            end
            mdl_entry_len = '0;
          end else if (key == KEY_STAR) begin
            mdl_entry_len = '0;
          end
        end
        CODE_CWAIT: begin
          if (key == KEY_STAR) begin
            mdl_entry_len = '0;
            mdl_state = CODE_OLD;
          end else if (key == KEY_HASH) begin
            m = enter_result(MSG_NEED_CHANGE);
          end
        end
        CODE_OLD: begin
          if (key <= KEY_DIGIT_MAX) begin
            push_digit(key);
          end else if (key == KEY_STAR) begin
            mdl_old = mdl_entry;
            mdl_old_len = mdl_entry_len;
            mdl_entry_len = '0;
            mdl_state = CODE_NEW;
          end else if (key == KEY_HASH) begin
            m = enter_result(MSG_NEED_NEW);
          end
        end
        CODE_NEW: begin
          if (key <= KEY_DIGIT_MAX) begin
            push_digit(key);
          end else if (key == KEY_HASH) begin
            if (same_code(mdl_old, mdl_old_len, mdl_code, mdl_code_len)) begin
              if (mdl_entry_len != 0) begin
                mdl_code = mdl_entry;
                mdl_code_len = mdl_entry_len;
                m = enter_result(MSG_CHANGED);
              end else begin
                m = enter_result(MSG_EMPTY_NEW);
              end
            end else begin
              m = enter_result(MSG_WRONG_OLD);
            end
            mdl_entry_len = '0;
            mdl_old_len = '0;
          end else if (key == KEY_STAR) begin
            mdl_entry_len = '0;
          end
        end
        CODE_STATUS: begin
          if (key == KEY_HASH) begin
            m = enter_result(mdl_locked ? MSG_STAT_LOCKED : MSG_STAT_UNLOCKED);
          end else if (key == KEY_STAR) begin
            mdl_state = CODE_MENU;
          end
        end
        CODE_RESULT: begin
          mdl_state = (key == KEY_STAR) ? CODE_MENU : CODE_IDLE;
        end
        default: begin
          mdl_state = (key == KEY_STAR) ? CODE_MENU : CODE_IDLE;
        end
      endcase
    end
    r.st  = mdl_state;
    r.lk  = mdl_locked;
    r.cnt = mdl_entry_len;
    r.msg = m;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
    if (errors < 40) begin
      $display("[%0t] mismatch on %s after %0d results: got %0d, want %0d",
               $realtime, what, checked, got, want);
    end
    errors++;
  endtask

  task automatic send_item(logic act, digit_t key);
    while ($urandom_range(99) < send_idle_pct) begin
      key_ch.valid <= 1'b0;
      @(posedge clk);
    end
    key_ch.valid    <= 1'b1;
    key_ch.action   <= act;
    key_ch.key_code <= key;
    @(posedge clk);
    while (!key_ch.ready) @(posedge clk);
    expected_reports.push_back(predict_lock_step(act, key));
    items_sent++;
  endtask

  task automatic wait_idle();
    key_ch.valid <= 1'b0;
    @(posedge clk);
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_timeout(logic [15:0] v);
    wait_idle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    mdl_timeout = v;
  endtask

  task automatic type_digits(int n);
    repeat (n) send_item(ACT_KEY, digit_t'($urandom_range(9)));
  endtask

  task automatic type_stored(bit corrupt);
    code_buf_t  c;
    logic [3:0] n;
    int         pos;
    c = mdl_code;
    n = mdl_code_len;
    if (corrupt) begin
      pos = $urandom_range(n - 1);
      c[pos] = (c[pos] == 4'd9) ? 4'd0 : c[pos] + 4'd1;
    end
    for (int i = 0; i < n; i++) send_item(ACT_KEY, c[i]);
  endtask

  // steer the machine back to the menu from wherever it sits
  task automatic reach_menu();
    while (mdl_state != CODE_MENU) begin
      case (mdl_state)
        CODE_UWAIT, CODE_UENTRY, CODE_CWAIT, CODE_OLD, CODE_NEW:
          send_item(ACT_KEY, KEY_HASH);
        default:
          send_item(ACT_KEY, KEY_STAR);
      endcase
    end
  endtask

  task automatic random_session();
    int     op;
    digit_t k;
    if ($urandom_range(99) < 20) begin
      send_item(logic'($urandom_range(1)), digit_t'($urandom_range(15)));
      return;
    end
    reach_menu();
    op = $urandom_range(4);
    case (op)
      0: begin
        send_item(ACT_KEY, KEY_OPT_LOCK);
        if ($urandom_range(7) == 0) begin
          send_item(ACT_KEY, KEY_STAR);
          send_item(ACT_KEY, KEY_OPT_LOCK);
        end
        send_item(ACT_KEY, KEY_HASH);
      end
      1: begin
        send_item(ACT_KEY, KEY_OPT_UNLOCK);
        if ($urandom_range(9) == 0) begin
          send_item(ACT_KEY, KEY_HASH);
        end else begin
          send_item(ACT_KEY, KEY_STAR);
          if ($urandom_range(7) == 0) begin
            type_digits($urandom_range(1, 5));
            send_item(ACT_KEY, KEY_STAR);
          end
          if ($urandom_range(2) != 0) type_stored($urandom_range(3) == 0);
          else type_digits($urandom_range(10));
          send_item(ACT_KEY, KEY_HASH);
        end
      end
      2: begin
        send_item(ACT_KEY, KEY_OPT_CHANGE);
        if ($urandom_range(9) == 0) begin
          send_item(ACT_KEY, KEY_HASH);
        end else begin
          send_item(ACT_KEY, KEY_STAR);
          if ($urandom_range(2) != 0) type_stored($urandom_range(4) == 0);
          else type_digits($urandom_range(10));
          if ($urandom_range(9) == 0) begin
            send_item(ACT_KEY, KEY_HASH);
          end else begin
            send_item(ACT_KEY, KEY_STAR);
            if ($urandom_range(9) == 0) type_digits(0);
            else type_digits($urandom_range(1, 10));
            send_item(ACT_KEY, KEY_HASH);
          end
        end
      end
      3: begin
        send_item(ACT_KEY, KEY_OPT_STATUS);
        if ($urandom_range(7) == 0) begin
          send_item(ACT_KEY, KEY_STAR);
          send_item(ACT_KEY, KEY_OPT_STATUS);
        end
        send_item(ACT_KEY, KEY_HASH);
      end
      default: begin
        k = digit_t'($urandom_range(4, 15));
        if (k == KEY_STAR) k = KEY_HASH;
        send_item(ACT_KEY, k);
      end
    endcase
    repeat ($urandom_range(4)) send_item(ACT_TICK, digit_t'($urandom_range(15)));
  endtask

  task automatic test_random_sessions(int n);
    int stop_at;
    stop_at = items_sent + n;
    while (items_sent < stop_at) random_session();
  endtask

  task automatic test_directed();
    digit_t walk[$];
    walk = '{KEY_STAR, 4'd15, KEY_STAR, KEY_OPT_LOCK, KEY_HASH};
    foreach (walk[i]) send_item(ACT_KEY, walk[i]);
    send_item(ACT_TICK, KEY_OTHER);
    walk = '{KEY_STAR, KEY_OPT_STATUS, KEY_HASH, KEY_STAR, KEY_OPT_UNLOCK, KEY_STAR,
             4'd1, 4'd2, 4'd3, 4'd4, KEY_HASH, KEY_STAR, KEY_OPT_CHANGE, KEY_STAR,
             4'd1, 4'd2, 4'd3, 4'd4, KEY_STAR, KEY_HASH, KEY_OTHER};
    foreach (walk[i]) send_item(ACT_KEY, walk[i]);
  endtask

  // receiver stalls for a long stretch while the sender keeps pushing
  task automatic test_backpressure();
    hold_starts++;
    repeat (8) random_session();
  endtask

  // largest timeout: the result state holds through a long run of ticks
  task automatic test_timeout_max();
    write_timeout(TICKS_MAX);
    reach_menu();
    send_item(ACT_KEY, KEY_OPT_STATUS);
    send_item(ACT_KEY, KEY_HASH);
    repeat (LONG_TICKS) send_item(ACT_TICK, digit_t'($urandom_range(15)));
    send_item(ACT_KEY, KEY_OTHER);
  endtask

  always @(posedge clk) begin
    if (hold_starts != hold_seen) begin
      hold_seen <= hold_starts;
      hold_left <= HOLD_CYCLES;
      res_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      res_ch.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin : check_p
    lock_report_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (expected_reports.size() == 0) begin
        report_mismatch("result with nothing pending", 16'(res_ch.machine_state), 16'hx);
      end else begin
        want = expected_reports.pop_front();
        if (res_ch.machine_state !== want.st)
          report_mismatch("machine_state", 16'(res_ch.machine_state), 16'(want.st));
        if (res_ch.locked !== want.lk)
          report_mismatch("locked", 16'(res_ch.locked), 16'(want.lk));
        if (res_ch.entered_count !== want.cnt)
          report_mismatch("entered_count", 16'(res_ch.entered_count), 16'(want.cnt));
        if (res_ch.message !== want.msg)
          report_mismatch("message", 16'(res_ch.message), 16'(want.msg));
        msg_count[want.msg]++;
        checked++;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (key_ch.valid && key_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles, %0d results pending",
               stall_cycles, expected_reports.size());
      $display("FAIL keypad_code_lock_controller");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    rst             <= 1'b1;
    cfg_wr_en       <= 1'b0;
    cfg_wr_data     <= '0;
    key_ch.valid    <= 1'b0;
    key_ch.action   <= ACT_KEY;
    key_ch.key_code <= KEY_OTHER;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    send_idle_pct = 17;
    recv_idle_pct = 78;
    test_directed();
    test_random_sessions(350);
    write_timeout(16'd1);
    test_random_sessions(150);

    send_idle_pct = 78;
    recv_idle_pct = 17;
    write_timeout(16'($urandom_range(2, 6)));
    test_random_sessions(350);
    test_backpressure();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_timeout(16'd3);
    test_random_sessions(300);
    test_timeout_max();

    wait_idle();
    if (expected_reports.size() != 0)
      report_mismatch("results never delivered", 16'(expected_reports.size()), 16'd0);
    $display("Checked %0d results from %0d transactions, timeouts 1 to 65535.",
             checked, items_sent);
    $display("Grants %0d, wrong codes %0d, changes %0d, empty new %0d, wrong old %0d.",
             msg_count[MSG_GRANTED], msg_count[MSG_WRONG_CODE], msg_count[MSG_CHANGED],
             msg_count[MSG_EMPTY_NEW], msg_count[MSG_WRONG_OLD]);
    if (errors == 0) begin
      $display("PASS keypad_code_lock_controller");
    end else begin
      $display("FAIL keypad_code_lock_controller");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+rtl
rtl/kclc_pkg.sv
rtl/kclc_key_if.sv
rtl/kclc_report_if.sv
rtl/keypad_code_lock_controller.sv
tb/tb_top.sv
